// ===== rtl/htfd_pkg.sv =====
// htfd_pkg: shared types, constants and the crc-8 step of the frame decoder
// no dependencies; imported by the front, queue, back and top modules of the decoder

package htfd_pkg;

    // crc-8 over each data word, msb first, no reflection, no final xor
    localparam logic [7:0] CRC_INIT = 8'hFF;
    localparam logic [7:0] CRC_POLY = 8'h31;

    // fixed-point scaling: centi = floor(word * scale / 65535) - offset
    localparam logic [14:0] TEMP_SCALE  = 15'd17500;
    localparam logic [14:0] HUM_SCALE   = 15'd12500;
    localparam logic [14:0] TEMP_OFFSET = 15'd4500;
    localparam logic [14:0] HUM_OFFSET  = 15'd600;

    // default depth of the frame queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // byte position within a six-byte measurement frame
    typedef enum logic [2:0] {
        POS_TEMP_HI  = 3'd0,
        POS_TEMP_LO  = 3'd1,
        POS_TEMP_CRC = 3'd2,
        POS_HUM_HI   = 3'd3,
        POS_HUM_LO   = 3'd4,
        POS_HUM_CRC  = 3'd5
    } t_byte_pos;

    // one complete frame handed from front to back
    typedef struct packed {
        logic [15:0] temperature_word;
        logic [15:0] humidity_word;
        logic        mismatch;
    } t_frame;

    // push of a finished frame from the front
    typedef struct packed {
        logic   push;
        t_frame frame;
    } t_front_out;

    // one byte through the crc register, eight shift steps
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int i = 0; i < 8; i++) begin
            c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

endpackage

// ===== rtl/htfd_front.sv =====
// htfd_front: byte position tracking, word assembly and crc check per frame
// depends on htfd_pkg (t_byte_pos, t_front_out, crc8_byte)

module htfd_front import htfd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_data_byte,
    input  logic       i_frame_start,
    output t_front_out o_out
);

    t_byte_pos   r_pos, n_pos, eff_pos;
    logic [7:0]  r_crc, n_crc;
    logic [15:0] r_temp, n_temp;
    logic [15:0] r_hum, n_hum;
    logic        r_mismatch, n_mismatch;

    // frame start or a stray position restarts at byte zero
    always_comb begin
        eff_pos = r_pos;
        if (i_frame_start || (r_pos > POS_HUM_CRC)) begin
            eff_pos = POS_TEMP_HI;
        end
    end

    // per-byte update
    always_comb begin
        n_pos      = r_pos;
        n_crc      = r_crc;
        n_temp     = r_temp;
        n_hum      = r_hum;
        n_mismatch = r_mismatch;
        o_out      = '0;
        o_out.frame.temperature_word = r_temp;
        o_out.frame.humidity_word    = r_hum;
        o_out.frame.mismatch         = r_mismatch | (r_crc != i_data_byte);
        if (i_accept) begin
            n_pos = t_byte_pos'(eff_pos + 3'd1);
            case (eff_pos)
                POS_TEMP_HI: begin
                    n_mismatch = 1'b0;
                    n_crc      = crc8_byte(CRC_INIT, i_data_byte);
                    n_temp     = {i_data_byte, 8'h00};
                end
                POS_TEMP_LO: begin
                    n_crc  = crc8_byte(r_crc, i_data_byte);
                    n_temp = {r_temp[15:8], i_data_byte};
                end
                POS_TEMP_CRC: begin
                    n_mismatch = r_mismatch | (r_crc != i_data_byte);
                    n_crc      = CRC_INIT;
                end
                POS_HUM_HI: begin
                    n_crc = crc8_byte(CRC_INIT, i_data_byte);
                    n_hum = {i_data_byte, 8'h00};
                end
                POS_HUM_LO: begin
                    n_crc = crc8_byte(r_crc, i_data_byte);
                    n_hum = {r_hum[15:8], i_data_byte};
                end
                POS_HUM_CRC: begin
                    n_mismatch = r_mismatch | (r_crc != i_data_byte);
                    n_crc      = CRC_INIT;
                    n_pos      = POS_TEMP_HI;
                    o_out.push = 1'b1;
                end
                default: begin
                    n_pos = POS_TEMP_HI;
                end
            endcase
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= POS_TEMP_HI;
            r_crc      <= CRC_INIT;
            r_temp     <= '0;
            r_hum      <= '0;
            r_mismatch <= 1'b0;
        end else begin
            r_pos      <= n_pos;
            r_crc      <= n_crc;
            r_temp     <= n_temp;
            r_hum      <= n_hum;
            r_mismatch <= n_mismatch;
        end
    end

endmodule

// ===== rtl/htfd_queue.sv =====
// htfd_queue: small frame queue between the front and the back
// depends on htfd_pkg (t_frame, QUEUE_DEPTH)

module htfd_queue import htfd_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_frame i_frame,
    input  logic   i_pop,
    output t_frame o_head,
    output logic   o_full,
    output logic   o_empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_frame             r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]   r_count, n_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];

    // pointer and count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_frame;
        end
    end

endmodule

// ===== rtl/htfd_back.sv =====
// htfd_back: scaling pipeline, multiply stage then divide-by-65535 and offset
// depends on htfd_pkg (t_frame, scale and offset constants)

module htfd_back import htfd_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  t_frame             i_frame,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [14:0] o_temperature_centi,
    output logic signed [14:0] o_humidity_centi,
    output logic [15:0]        o_temperature_word,
    output logic [15:0]        o_humidity_word,
    output logic               o_crc_status
);

    // floor(prod / 65535) for prod below 65535 * 32768
    function automatic logic [14:0] div_65535(input logic [30:0] prod);
        logic [14:0] q;
        logic [16:0] rem;
        q   = prod[30:16];
        rem = {1'b0, prod[15:0]} + {2'b00, q};
        if (rem >= 17'h0FFFF) begin
            q = q + 1'b1;
        end
        return q;
    endfunction

    logic        r_s1_valid;
    logic [30:0] r_s1_tprod, r_s1_hprod;
    t_frame      r_s1_frame;
    logic        r_out_valid;
    logic        out_ready, s1_ready;
    logic [14:0] n_temp_centi, n_hum_centi;

    assign out_ready = !r_out_valid || !i_stall;
    assign s1_ready  = !r_s1_valid || out_ready;
    assign o_pop     = i_valid && s1_ready;
    assign o_valid   = r_out_valid;

    // multiply stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_ready) begin
            r_s1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_s1_tprod <= 31'(i_frame.temperature_word) * 31'(TEMP_SCALE);
            r_s1_hprod <= 31'(i_frame.humidity_word) * 31'(HUM_SCALE);
            r_s1_frame <= i_frame;
        end
    end

    // divide and offset, wraps into the signed 15-bit result
    always_comb begin
        n_temp_centi = div_65535(r_s1_tprod) - TEMP_OFFSET;
        n_hum_centi  = div_65535(r_s1_hprod) - HUM_OFFSET;
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_ready) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_ready && r_s1_valid) begin
            o_temperature_centi <= $signed(n_temp_centi);
            o_humidity_centi    <= $signed(n_hum_centi);
            o_temperature_word  <= r_s1_frame.temperature_word;
            o_humidity_word     <= r_s1_frame.humidity_word;
            o_crc_status        <= r_s1_frame.mismatch;
        end
    end

endmodule

// ===== rtl/humidity_temperature_frame_decoder.sv =====
// humidity_temperature_frame_decoder: top level, front, frame queue and back
// depends on htfd_pkg, htfd_front, htfd_queue, htfd_back

// Takes one frame byte per cycle (temperature word high byte first, its
// crc-8, humidity word, its crc-8) and gives one item per six bytes with
// both raw words, the crc status and the scaled values in hundredths. A byte
// is taken in every cycle while the frame queue has room; the front stalls
// only when the queue (QUEUE_DEPTH frames) is full because the output side
// holds stall. After its sixth byte, a result item passes through the
// frame queue, the multiply stage and the divide and output stage, in
// that order. i_frame_start realigns the byte position and drops any
// partial frame.

module humidity_temperature_frame_decoder import htfd_pkg::*; #(
    parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [7:0]         i_data_byte,
    input  logic               i_frame_start,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [14:0] o_temperature_centi,
    output logic signed [14:0] o_humidity_centi,
    output logic [15:0]        o_temperature_word,
    output logic [15:0]        o_humidity_word,
    output logic               o_crc_status
);

    t_front_out front_out;
    t_frame     q_head;
    logic       q_full, q_empty, q_pop;
    logic       in_accept;

    assign o_stall   = q_full;
    assign in_accept = i_valid && !q_full;

    htfd_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (in_accept),
        .i_data_byte   (i_data_byte),
        .i_frame_start (i_frame_start),
        .o_out         (front_out)
    );

    htfd_queue #(
        .DEPTH (QUEUE_DEPTH_P)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_out.push),
        .i_frame (front_out.frame),
        .i_pop   (q_pop),
        .o_head  (q_head),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    htfd_back u_back (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (!q_empty),
        .i_frame             (q_head),
        .o_pop               (q_pop),
        .o_valid             (o_valid),
        .i_stall             (i_stall),
        .o_temperature_centi (o_temperature_centi),
        .o_humidity_centi    (o_humidity_centi),
        .o_temperature_word  (o_temperature_word),
        .o_humidity_word     (o_humidity_word),
        .o_crc_status        (o_crc_status)
    );

endmodule

// ===== rtl/htfd_checker.sv =====
// htfd_checker: port-level assertions for the frame decoder, bound to the top
// no package dependency; binds to humidity_temperature_frame_decoder

module htfd_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_stall,
    input logic [7:0]         i_data_byte,
    input logic               i_frame_start,
    input logic               o_valid,
    input logic               i_stall,
    input logic signed [14:0] o_temperature_centi,
    input logic signed [14:0] o_humidity_centi,
    input logic [15:0]        o_temperature_word,
    input logic [15:0]        o_humidity_word,
    input logic               o_crc_status
);

    // reset empties the output side
    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("output item valid right after reset");

    // a stalled result item holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_temperature_centi)
            && $stable(o_humidity_centi) && $stable(o_temperature_word)
            && $stable(o_humidity_word) && $stable(o_crc_status))
        else $error("stalled result item changed");

    // scaled temperature stays in range and matches the low word end point
    a_temp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_temperature_centi >= -15'sd4500) && (o_temperature_centi <= 15'sd13000)
            && ((o_temperature_word != 16'h0000) || (o_temperature_centi == -15'sd4500)))
        else $error("temperature out of range");

    // scaled humidity stays in range and matches the high word end point
    a_hum_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_humidity_centi >= -15'sd600) && (o_humidity_centi <= 15'sd11900)
            && ((o_humidity_word != 16'hFFFF) || (o_humidity_centi == 15'sd11900)))
        else $error("humidity out of range");

endmodule

bind humidity_temperature_frame_decoder htfd_checker u_htfd_checker (.*);

// ===== dv/tb_humidity_temperature_frame_decoder.sv =====
// tb_humidity_temperature_frame_decoder: self-checking bench for the frame decoder
// drives byte items with random gaps and stalls, predicts readings with crc-8 and scaling
// depends on htfd_pkg and humidity_temperature_frame_decoder

module tb_humidity_temperature_frame_decoder;
    timeunit 1ns;
    timeprecision 1ps;

    import htfd_pkg::*;

    localparam int unsigned WORD_FULL   = 65535;
    localparam int          REPORT_MAX  = 10;
    localparam int          RANDOM_BYTES = 500;

    // one byte item as queued for the driver
    typedef struct packed {
        logic [7:0] data;
        logic       start;
        logic       drain;
    } t_byte_item;

    // one decoded reading
    typedef struct packed {
        logic signed [14:0] temp_centi;
        logic signed [14:0] hum_centi;
        logic [15:0]        temp_word;
        logic [15:0]        hum_word;
        logic               crc_bad;
    } t_reading;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic [7:0]         i_data_byte = 8'h00;
    logic               i_frame_start = 1'b0;
    logic               i_stall = 1'b0;
    logic               o_stall;
    logic               o_valid;
    logic signed [14:0] o_temperature_centi;
    logic signed [14:0] o_humidity_centi;
    logic [15:0]        o_temperature_word;
    logic [15:0]        o_humidity_word;
    logic               o_crc_status;

    humidity_temperature_frame_decoder dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_stall             (o_stall),
        .i_data_byte         (i_data_byte),
        .i_frame_start       (i_frame_start),
        .o_valid             (o_valid),
        .i_stall             (i_stall),
        .o_temperature_centi (o_temperature_centi),
        .o_humidity_centi    (o_humidity_centi),
        .o_temperature_word  (o_temperature_word),
        .o_humidity_word     (o_humidity_word),
        .o_crc_status        (o_crc_status)
    );

    t_byte_item pending_bytes[$];
    t_reading   expected_readings[$];

    // decoder state mirrored by the predictor
    t_byte_pos  frame_pos = POS_TEMP_HI;
    logic [7:0] word_crc = CRC_INIT;
    logic [15:0] temp_acc = 16'h0000;
    logic [15:0] hum_acc = 16'h0000;
    logic        crc_fail = 1'b0;

    int bytes_sent = 0;
    int readings_checked = 0;
    int crc_fail_readings = 0;
    int restarts = 0;
    int mismatches = 0;
    int send_gap = 0;
    int send_run = 0;
    int stall_left = 0;
    int stall_run = 0;

    logic     took_reading = 1'b0;
    t_reading took_item;

    // clock
    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // crc-8, one message bit at a time, msb first
    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] r;
        r = crc;
        for (int k = 7; k >= 0; k--) begin
            if (r[7] ^ data[k]) r = (r << 1) ^ CRC_POLY;
            else r = r << 1;
        end
        return r;
    endfunction

    // floor(word * span / 65535) - offset, kept to 15 bits
    function automatic logic signed [14:0] to_centi(input logic [15:0] word,
                                                   input int unsigned span,
                                                   input int unsigned offset);
        int unsigned q;
        q = (word * span) / WORD_FULL;
        return 15'(q - offset);
    endfunction

    // idle length: mostly none, some short, few long, with idle-free stretches
    function automatic int draw_idle(inout int run_left);
        int r;
        if (run_left > 0) begin
            run_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3) begin
            run_left = $urandom_range(20, 60);
            return 0;
        end
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    // advance the mirrored decoder by one accepted byte
    task automatic track_byte(input logic [7:0] b, input logic start);
        t_byte_pos pos;
        t_reading  r;
        pos = frame_pos;
        if (start || pos > POS_HUM_CRC) begin
            if (start && pos != POS_TEMP_HI) restarts++;
            pos = POS_TEMP_HI;
        end
        case (pos)
            POS_TEMP_HI: begin
                crc_fail = 1'b0;
                word_crc = crc8_step(CRC_INIT, b);
                temp_acc = {b, 8'h00};
            end
            POS_TEMP_LO: begin
                word_crc = crc8_step(word_crc, b);
                temp_acc[7:0] = b;
            end
            POS_TEMP_CRC: begin
                if (word_crc != b) crc_fail = 1'b1;
                word_crc = CRC_INIT;
            end
            POS_HUM_HI: begin
                word_crc = crc8_step(CRC_INIT, b);
                hum_acc = {b, 8'h00};
            end
            POS_HUM_LO: begin
                word_crc = crc8_step(word_crc, b);
                hum_acc[7:0] = b;
            end
            default: begin
                if (word_crc != b) crc_fail = 1'b1;
                word_crc = CRC_INIT;
                r.temp_centi = to_centi(temp_acc, TEMP_SCALE, TEMP_OFFSET);
                r.hum_centi  = to_centi(hum_acc, HUM_SCALE, HUM_OFFSET);
                r.temp_word  = temp_acc;
                r.hum_word   = hum_acc;
                r.crc_bad    = crc_fail;
                expected_readings.push_back(r);
            end
        endcase
        frame_pos = (pos == POS_HUM_CRC) ? POS_TEMP_HI : t_byte_pos'(pos + 3'd1);
    endtask

    task automatic add_byte(input logic [7:0] data, input logic start, input logic drain);
        t_byte_item it;
        it.data  = data;
        it.start = start;
        it.drain = drain;
        pending_bytes.push_back(it);
    endtask

    // full frame, optionally with corrupted crc bytes
    task automatic add_frame(input logic [15:0] t, input logic [15:0] h, input logic start,
                             input logic bad_t, input logic bad_h, input logic drain);
        logic [7:0] ct;
        logic [7:0] ch;
        ct = crc8_step(crc8_step(CRC_INIT, t[15:8]), t[7:0]);
        ch = crc8_step(crc8_step(CRC_INIT, h[15:8]), h[7:0]);
        if (bad_t) ct ^= 8'($urandom_range(1, 255));
        if (bad_h) ch ^= 8'($urandom_range(1, 255));
        add_byte(t[15:8], start, drain);
        add_byte(t[7:0], 1'b0, 1'b0);
        add_byte(ct, 1'b0, 1'b0);
        add_byte(h[15:8], 1'b0, 1'b0);
        add_byte(h[7:0], 1'b0, 1'b0);
        add_byte(ch, 1'b0, 1'b0);
    endtask

    function automatic logic [15:0] pick_word();
        case ($urandom_range(0, 9))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // driver: presents queued byte items, holds them while stalled
    always @(posedge i_clk) begin
        t_byte_item nxt;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!(i_valid && o_stall)) begin
            if (i_valid) begin
                track_byte(i_data_byte, i_frame_start);
                bytes_sent++;
            end
            if (send_gap > 0) begin
                send_gap--;
                i_valid <= 1'b0;
            end else if (pending_bytes.size() > 0 &&
                         !(pending_bytes[0].drain && expected_readings.size() > 0)) begin
                nxt = pending_bytes.pop_front();
                i_valid       <= 1'b1;
                i_data_byte   <= nxt.data;
                i_frame_start <= nxt.start;
                send_gap = draw_idle(send_run);
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // monitor: random stall and capture of accepted readings
    always @(posedge i_clk) begin
        took_reading <= i_rst_n && o_valid && !i_stall;
        took_item    <= '{o_temperature_centi, o_humidity_centi, o_temperature_word,
                          o_humidity_word, o_crc_status};
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_stall <= 1'b1;
        end else begin
            stall_left = draw_idle(stall_run);
            i_stall <= (stall_left > 0);
            if (stall_left > 0) stall_left--;
        end
    end

    // compare each captured reading with the oldest prediction
    always @(negedge i_clk) begin
        t_reading want;
        if (took_reading) begin
            readings_checked++;
            if (took_item.crc_bad) crc_fail_readings++;
            if (expected_readings.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("%0t: unexpected reading t=%0d h=%0d tw=%h hw=%h crc=%b",
                             $realtime, took_item.temp_centi, took_item.hum_centi,
                             took_item.temp_word, took_item.hum_word, took_item.crc_bad);
            end else begin
                want = expected_readings.pop_front();
                if (want !== took_item) begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("%0t: reading mismatch exp t=%0d h=%0d tw=%h hw=%h crc=%b %s",
                                 $realtime, want.temp_centi, want.hum_centi, want.temp_word,
                                 want.hum_word, want.crc_bad, "/");
                    if (mismatches <= REPORT_MAX)
                        $display("    got t=%0d h=%0d tw=%h hw=%h crc=%b",
                                 took_item.temp_centi, took_item.hum_centi,
                                 took_item.temp_word, took_item.hum_word, took_item.crc_bad);
                end
            end
        end
    end

    // stimulus, reset and end of run
    initial begin
        int roll;
        int n;
        logic force_start;

        // directed: extreme words, bad crc on each word, wrap without start, mid-frame restart
        add_frame(16'h0000, 16'hFFFF, 1'b1, 1'b0, 1'b0, 1'b0);
        add_frame(16'hFFFF, 16'h0000, 1'b0, 1'b1, 1'b0, 1'b1);
        add_byte(8'hFF, 1'b1, 1'b0);
        add_byte(8'h00, 1'b0, 1'b0);
        add_frame(16'h6666, 16'h8000, 1'b1, 1'b0, 1'b1, 1'b0);

        // random: mostly well-formed frames, some cut short, some noise
        force_start = 1'b0;
        while (pending_bytes.size() < RANDOM_BYTES + 20) begin
            roll = $urandom_range(0, 99);
            if (roll < 80) begin
                add_frame(pick_word(), pick_word(),
                          force_start || ($urandom_range(0, 3) != 0),
                          ($urandom_range(0, 9) == 0), ($urandom_range(0, 9) == 0),
                          ($urandom_range(0, 49) == 0));
                force_start = 1'b0;
            end else if (roll < 92) begin
                n = $urandom_range(1, 5);
                for (int k = 0; k < n; k++)
                    add_byte(8'($urandom), (k == 0), 1'b0);
                force_start = 1'b1;
            end else begin
                n = $urandom_range(1, 8);
                for (int k = 0; k < n; k++)
                    add_byte(8'($urandom), ($urandom_range(0, 7) == 0), 1'b0);
            end
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_bytes.size() > 0 || i_valid) @(posedge i_clk);
        while (expected_readings.size() > 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        @(negedge i_clk);

        if (expected_readings.size() > 0) begin
            mismatches += expected_readings.size();
            $display("%0d predicted readings never arrived", expected_readings.size());
        end
        $display("sent %0d bytes, checked %0d readings (%0d flagged crc failure)",
                 bytes_sent, readings_checked, crc_fail_readings);
        $display("%0d frames restarted part way, %0d mismatches", restarts, mismatches);
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // watchdog
    initial begin
        #2_000_000;
        $display("timeout with %0d readings outstanding", expected_readings.size());
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
